@@ design/ffha_pkg.sv @@
package ffha_pkg;

  localparam int ARENA_PAGES  = 64;
  localparam int PAGE_BYTES   = 4096;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 32;
  localparam int SPLIT_MIN    = 16;
  localparam int ARENA_BYTES  = ARENA_PAGES * PAGE_BYTES;
  localparam int GRANULES     = ARENA_BYTES / ALIGN_BYTES;

  localparam int IDX_W  = $clog2(GRANULES);
  localparam int PTR_W  = IDX_W + 2;
  localparam int SZ_W   = 18;
  localparam int OFF_W  = 19;
  localparam int PG_W   = 7;
  localparam int CMP_W  = 20;
  localparam int AL_SH  = $clog2(ALIGN_BYTES);
  localparam int PG_SH  = $clog2(PAGE_BYTES);
  localparam int HDR_GR = HEADER_BYTES / ALIGN_BYTES;

  // action codes
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_REFUSED = 2'd1;
  localparam logic [1:0] STAT_NOMEM   = 2'd2;
  localparam logic [1:0] STAT_INITF   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_INIT_PAGES = 2'd0;
  localparam logic [1:0] CFG_PAGE_LIMIT = 2'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_START,
    ST_A_RD,
    ST_A_CHK,
    ST_A_SPL,
    ST_A_WS,
    ST_A_WI,
    ST_G_CALC,
    ST_G_RDT,
    ST_G_CHT,
    ST_G_NEW,
    ST_F_WALK,
    ST_F_NXT,
    ST_F_CHK,
    ST_F_NCHK,
    ST_F_PREV,
    ST_F_PRD,
    ST_F_PCHK,
    ST_I_START,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_size_en;
    logic [SZ_W-1:0]  wr_size;
    logic             wr_free_en;
    logic             wr_free;
    logic             wr_prev_en;
    logic [IDX_W-1:0] wr_prev_addr;
    logic [IDX_W-1:0] wr_prev;
  } store_req_t;

  typedef struct packed {
    logic [SZ_W-1:0]  size;
    logic             free;
    logic [IDX_W-1:0] prev;
  } store_rsp_t;

  // granule index of the block that follows block i of the given size
  function automatic logic [PTR_W-1:0] next_of(input logic [PTR_W-1:0] i,
                                               input logic [SZ_W-1:0] s);
    next_of = i + PTR_W'(HDR_GR) + PTR_W'(s >> AL_SH);
  endfunction

endpackage

@@ design/ffha_store.sv @@
module ffha_store (
  input  logic                clk,
  input  ffha_pkg::store_req_t req,
  output ffha_pkg::store_rsp_t rsp
);
  import ffha_pkg::*;

  logic [SZ_W-1:0]  size_mem [GRANULES];
  logic             free_mem [GRANULES];
  logic [IDX_W-1:0] prev_mem [GRANULES];

  // write the header fields, read one header with registered data
  always_ff @(posedge clk) begin
    if (req.wr_size_en) begin
      size_mem[req.wr_addr] <= req.wr_size;
    end
    if (req.wr_free_en) begin
      free_mem[req.wr_addr] <= req.wr_free;
    end
    if (req.wr_prev_en) begin
      prev_mem[req.wr_prev_addr] <= req.wr_prev;
    end
    rsp.size <= size_mem[req.rd_addr];
    rsp.free <= free_mem[req.rd_addr];
    rsp.prev <= prev_mem[req.rd_addr];
  end

endmodule

@@ design/ffha_alu.sv @@
module ffha_alu (
  input  logic [ffha_pkg::CMP_W-1:0] a,
  input  logic [ffha_pkg::CMP_W-1:0] b,
  output logic                      ge
);
  import ffha_pkg::*;

  logic [CMP_W:0] diff;

  // subtract and take the borrow as the compare result
  assign diff = {1'b0, a} - {1'b0, b};
  assign ge   = ~diff[CMP_W];

endmodule

@@ design/ffha_seq.sv @@
module ffha_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_action,
  input  logic [ffha_pkg::OFF_W-1:0] in_request_size,
  input  logic [ffha_pkg::OFF_W-1:0] in_payload_offset,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [ffha_pkg::OFF_W-1:0] out_result_offset,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [ffha_pkg::PG_W-1:0]  cfg_wdata,
  output ffha_pkg::store_req_t       store_req,
  input  ffha_pkg::store_rsp_t       store_rsp,
  output logic [ffha_pkg::CMP_W-1:0] alu_a,
  output logic [ffha_pkg::CMP_W-1:0] alu_b,
  input  logic                       alu_ge
);
  import ffha_pkg::*;

  localparam logic [PTR_W-1:0] GR_END = PTR_W'(GRANULES);

  state_t           state_r, state_nxt;
  logic [PG_W-1:0]  mapped_r, mapped_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [PG_W-1:0]  init_pages_r, page_limit_r;
  logic [1:0]       act_r, act_nxt;
  logic [PTR_W-1:0] cur_r, cur_nxt;
  logic [PTR_W-1:0] t_r, t_nxt;
  logic [PTR_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] p_r, p_nxt;
  logic [OFF_W-1:0] need_r, need_nxt;
  logic [PG_W-1:0]  pages_r, pages_nxt;
  logic [SZ_W-1:0]  sz_r, sz_nxt;
  logic             split_r, split_nxt;
  logic             empty_r, empty_nxt;
  logic [PG_W-1:0]  gn_r, gn_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [OFF_W-1:0] result_r, result_nxt;

  logic [PTR_W-1:0] nx_rsp, nx_sz, nn_rsp, split_idx;
  logic [PG_W-1:0]  limit, avail, gn_calc;
  logic [OFF_W-1:0] region;
  logic [OFF_W:0]   need_calc;
  logic [OFF_W:0]   pages_sum;
  logic [SZ_W-1:0]  merged_sz;

  // neighbour indexes and growth amounts
  assign nx_rsp    = next_of(cur_r, store_rsp.size);
  assign nx_sz     = next_of(cur_r, sz_r);
  assign nn_rsp    = next_of(n_r, store_rsp.size);
  assign split_idx = cur_r + PTR_W'(HDR_GR) + PTR_W'(need_r >> AL_SH);
  assign limit     = (page_limit_r > PG_W'(ARENA_PAGES)) ? PG_W'(ARENA_PAGES) : page_limit_r;
  assign avail     = (limit > mapped_r) ? limit - mapped_r : '0;
  assign gn_calc   = (pages_r < avail) ? pages_r : avail;
  assign region    = OFF_W'(gn_r) << PG_SH;
  assign need_calc = ({1'b0, in_request_size} + (OFF_W+1)'(ALIGN_BYTES - 1))
                     & ~(OFF_W+1)'(ALIGN_BYTES - 1);
  assign pages_sum = need_calc + (OFF_W+1)'(HEADER_BYTES + PAGE_BYTES - 1);
  assign merged_sz = sz_r + SZ_W'(HEADER_BYTES) + store_rsp.size;

  assign cfg_ready         = 1'b1;
  assign out_status        = status_r;
  assign out_result_offset = result_r;

  // take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_pages_r <= PG_W'(16);
      page_limit_r <= PG_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INIT_PAGES: init_pages_r <= cfg_wdata;
        CFG_PAGE_LIMIT: page_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hold control state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mapped_r <= '0;
      head_r   <= '0;
      tail_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      mapped_r <= mapped_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    cur_r    <= cur_nxt;
    t_r      <= t_nxt;
    n_r      <= n_nxt;
    p_r      <= p_nxt;
    need_r   <= need_nxt;
    pages_r  <= pages_nxt;
    sz_r     <= sz_nxt;
    split_r  <= split_nxt;
    empty_r  <= empty_nxt;
    gn_r     <= gn_nxt;
    status_r <= status_nxt;
    result_r <= result_nxt;
  end

  // advance the sequencer
  always_comb begin
    state_nxt  = state_r;
    mapped_nxt = mapped_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    act_nxt    = act_r;
    cur_nxt    = cur_r;
    t_nxt      = t_r;
    n_nxt      = n_r;
    p_nxt      = p_r;
    need_nxt   = need_r;
    pages_nxt  = pages_r;
    sz_nxt     = sz_r;
    split_nxt  = split_r;
    empty_nxt  = empty_r;
    gn_nxt     = gn_r;
    status_nxt = status_r;
    result_nxt = result_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt    = in_action;
          result_nxt = '0;
          status_nxt = STAT_OK;
          unique case (in_action)
            ACT_ALLOC: begin
              if (in_request_size == '0) begin
                status_nxt = STAT_REFUSED;
                state_nxt  = ST_DONE;
              end else if (in_request_size > OFF_W'(ARENA_BYTES)) begin
                status_nxt = STAT_NOMEM;
                state_nxt  = ST_DONE;
              end else begin
                need_nxt  = need_calc[OFF_W-1:0];
                pages_nxt = pages_sum[PG_SH+PG_W-1:PG_SH];
                state_nxt = ST_A_START;
              end
            end
            ACT_FREE: begin
              if (in_payload_offset == '0) begin
                status_nxt = STAT_REFUSED;
                state_nxt  = ST_DONE;
              end else if (mapped_r == '0 || in_payload_offset < OFF_W'(HEADER_BYTES) ||
                           in_payload_offset[AL_SH-1:0] != '0) begin
                state_nxt = ST_DONE;
              end else begin
                t_nxt     = PTR_W'((in_payload_offset - OFF_W'(HEADER_BYTES)) >> AL_SH);
                cur_nxt   = PTR_W'(head_r);
                state_nxt = ST_F_WALK;
              end
            end
            ACT_INIT: state_nxt = ST_I_START;
            default: begin
              status_nxt = STAT_REFUSED;
              state_nxt  = ST_DONE;
            end
          endcase
        end
      end
      ST_A_START: begin
        if (mapped_r != '0) begin
          cur_nxt   = PTR_W'(head_r);
          state_nxt = ST_A_RD;
        end else begin
          state_nxt = ST_G_CALC;
        end
      end
      ST_A_RD: state_nxt = ST_A_CHK;
      ST_A_CHK: begin
        sz_nxt = store_rsp.size;
        if (store_rsp.free && alu_ge) begin
          state_nxt = ST_A_SPL;
        end else if (cur_r == PTR_W'(tail_r) || nx_rsp >= GR_END) begin
          state_nxt = ST_G_CALC;
        end else begin
          cur_nxt   = nx_rsp;
          state_nxt = ST_A_RD;
        end
      end
      ST_A_SPL: begin
        split_nxt = alu_ge;
        n_nxt     = split_idx;
        if (alu_ge) begin
          if (cur_r == PTR_W'(tail_r)) begin
            tail_nxt = split_idx[IDX_W-1:0];
          end
          state_nxt = ST_A_WS;
        end else begin
          state_nxt = ST_A_WI;
        end
      end
      ST_A_WS: state_nxt = ST_A_WI;
      ST_A_WI: begin
        result_nxt = (OFF_W'(cur_r[IDX_W-1:0]) << AL_SH) + OFF_W'(HEADER_BYTES);
        status_nxt = STAT_OK;
        state_nxt  = ST_DONE;
      end
      ST_G_CALC: begin
        if (gn_calc == '0) begin
          status_nxt = (act_r == ACT_INIT) ? STAT_INITF : STAT_NOMEM;
          state_nxt  = ST_DONE;
        end else begin
          gn_nxt     = gn_calc;
          mapped_nxt = mapped_r + gn_calc;
          empty_nxt  = (mapped_r == '0);
          n_nxt      = PTR_W'(mapped_r) << (PG_SH - AL_SH);
          state_nxt  = (mapped_r != '0) ? ST_G_RDT : ST_G_NEW;
        end
      end
      ST_G_RDT: state_nxt = ST_G_CHT;
      ST_G_CHT: begin
        if (store_rsp.free) begin
          state_nxt = (act_r == ACT_INIT) ? ST_DONE : ST_A_START;
        end else begin
          state_nxt = ST_G_NEW;
        end
      end
      ST_G_NEW: begin
        if (empty_r) begin
          head_nxt = n_r[IDX_W-1:0];
        end
        tail_nxt  = n_r[IDX_W-1:0];
        state_nxt = (act_r == ACT_INIT) ? ST_DONE : ST_A_START;
      end
      ST_F_WALK: begin
        if (cur_r >= GR_END) begin
          state_nxt = ST_DONE;
        end else if (cur_r == t_r) begin
          state_nxt = ST_F_CHK;
        end else if (cur_r == PTR_W'(tail_r) || cur_r > t_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_F_NXT;
        end
      end
      ST_F_NXT: begin
        cur_nxt   = nx_rsp;
        state_nxt = ST_F_WALK;
      end
      ST_F_CHK: begin
        sz_nxt = store_rsp.size;
        if (store_rsp.free) begin
          state_nxt = ST_DONE;
        end else if (cur_r != PTR_W'(tail_r) && nx_rsp < GR_END) begin
          n_nxt     = nx_rsp;
          state_nxt = ST_F_NCHK;
        end else begin
          state_nxt = ST_F_PREV;
        end
      end
      ST_F_NCHK: begin
        if (store_rsp.free) begin
          sz_nxt = merged_sz;
          if (n_r == PTR_W'(tail_r)) begin
            tail_nxt = cur_r[IDX_W-1:0];
          end
        end
        state_nxt = ST_F_PREV;
      end
      ST_F_PREV: begin
        state_nxt = (cur_r != PTR_W'(head_r)) ? ST_F_PRD : ST_DONE;
      end
      ST_F_PRD: begin
        p_nxt     = store_rsp.prev;
        state_nxt = ST_F_PCHK;
      end
      ST_F_PCHK: begin
        if (store_rsp.free && cur_r == PTR_W'(tail_r)) begin
          tail_nxt = p_r;
        end
        state_nxt = ST_DONE;
      end
      ST_I_START: begin
        head_nxt   = '0;
        tail_nxt   = '0;
        mapped_nxt = '0;
        if (init_pages_r == '0) begin
          status_nxt = STAT_INITF;
          state_nxt  = ST_DONE;
        end else begin
          pages_nxt = init_pages_r;
          state_nxt = ST_G_CALC;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // drive header store, compare unit and handshake
  always_comb begin
    store_req   = '0;
    alu_a       = '0;
    alu_b       = '0;
    busy        = (state_r != ST_IDLE);
    out_valid   = (state_r == ST_DONE);
    unique case (state_r)
      ST_A_RD: store_req.rd_addr = cur_r[IDX_W-1:0];
      ST_A_CHK: begin
        alu_a = CMP_W'(store_rsp.size);
        alu_b = CMP_W'(need_r);
      end
      ST_A_SPL: begin
        alu_a = CMP_W'(sz_r);
        alu_b = CMP_W'(need_r) + CMP_W'(HEADER_BYTES + SPLIT_MIN);
        if (alu_ge && cur_r != PTR_W'(tail_r) && nx_sz < GR_END) begin
          store_req.wr_prev_en   = 1'b1;
          store_req.wr_prev_addr = nx_sz[IDX_W-1:0];
          store_req.wr_prev      = split_idx[IDX_W-1:0];
        end
      end
      ST_A_WS: begin
        store_req.wr_addr      = n_r[IDX_W-1:0];
        store_req.wr_size_en   = 1'b1;
        store_req.wr_size      = sz_r - SZ_W'(need_r) - SZ_W'(HEADER_BYTES);
        store_req.wr_free_en   = 1'b1;
        store_req.wr_free      = 1'b1;
        store_req.wr_prev_en   = 1'b1;
        store_req.wr_prev_addr = n_r[IDX_W-1:0];
        store_req.wr_prev      = cur_r[IDX_W-1:0];
      end
      ST_A_WI: begin
        store_req.wr_addr    = cur_r[IDX_W-1:0];
        store_req.wr_size_en = split_r;
        store_req.wr_size    = SZ_W'(need_r);
        store_req.wr_free_en = 1'b1;
        store_req.wr_free    = 1'b0;
      end
      ST_G_RDT: store_req.rd_addr = tail_r;
      ST_G_CHT: begin
        store_req.wr_addr    = tail_r;
        store_req.wr_size_en = store_rsp.free;
        store_req.wr_size    = store_rsp.size + SZ_W'(region);
      end
      ST_G_NEW: begin
        store_req.wr_addr      = n_r[IDX_W-1:0];
        store_req.wr_size_en   = 1'b1;
        store_req.wr_size      = SZ_W'(region - OFF_W'(HEADER_BYTES));
        store_req.wr_free_en   = 1'b1;
        store_req.wr_free      = 1'b1;
        store_req.wr_prev_en   = 1'b1;
        store_req.wr_prev_addr = n_r[IDX_W-1:0];
        store_req.wr_prev      = empty_r ? '0 : tail_r;
      end
      ST_F_WALK: store_req.rd_addr = cur_r[IDX_W-1:0];
      ST_F_CHK: begin
        store_req.rd_addr    = nx_rsp[IDX_W-1:0];
        store_req.wr_addr    = cur_r[IDX_W-1:0];
        store_req.wr_free_en = ~store_rsp.free;
        store_req.wr_free    = 1'b1;
      end
      ST_F_NCHK: begin
        store_req.wr_addr    = cur_r[IDX_W-1:0];
        store_req.wr_size_en = store_rsp.free;
        store_req.wr_size    = merged_sz;
        if (store_rsp.free && n_r != PTR_W'(tail_r) && nn_rsp < GR_END) begin
          store_req.wr_prev_en   = 1'b1;
          store_req.wr_prev_addr = nn_rsp[IDX_W-1:0];
          store_req.wr_prev      = cur_r[IDX_W-1:0];
        end
      end
      ST_F_PREV: store_req.rd_addr = cur_r[IDX_W-1:0];
      ST_F_PRD:  store_req.rd_addr = store_rsp.prev;
      ST_F_PCHK: begin
        store_req.wr_addr    = p_r;
        store_req.wr_size_en = store_rsp.free;
        store_req.wr_size    = store_rsp.size + SZ_W'(HEADER_BYTES) + sz_r;
        if (store_rsp.free && cur_r != PTR_W'(tail_r) && nx_sz < GR_END) begin
          store_req.wr_prev_en   = 1'b1;
          store_req.wr_prev_addr = nx_sz[IDX_W-1:0];
          store_req.wr_prev      = p_r;
        end
      end
      default: ;
    endcase
  end

  // a taken request leaves idle at once
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request taken but block not busy");

  // the result strobe lasts one cycle and frees the block
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid) else $error("result strobe not followed by idle");

  // the arena never exceeds its page count
  a_mapped_max: assert property (@(posedge clk) disable iff (!rst_n)
    mapped_r <= PG_W'(ARENA_PAGES)) else $error("mapped pages beyond arena");

  // a claimed block always reports success with a payload offset
  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_A_WI |=> out_valid && out_status == STAT_OK && out_result_offset != '0)
    else $error("allocation did not report its block");

endmodule

@@ design/first_fit_heap_allocator_top.sv @@
// Walk: an allocate visits blocks from the head, and each growth of the arena restarts the
//   walk from the head; a free passes blocks from the head until it reaches its own.
//   A refused request answers in the cycle after it is taken.
// Throughput: one request at a time; busy stays high until the result strobe, which the
//   receiver cannot stall. The header store's single read port sets the walk rate.
// Reset: synchronous, active low; the heap is empty and the registers take 16 and 64.
module first_fit_heap_allocator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_action,
  input  logic [ffha_pkg::OFF_W-1:0] in_request_size,
  input  logic [ffha_pkg::OFF_W-1:0] in_payload_offset,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [ffha_pkg::OFF_W-1:0] out_result_offset,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [ffha_pkg::PG_W-1:0]  cfg_wdata
);
  import ffha_pkg::*;

  store_req_t       store_req;
  store_rsp_t       store_rsp;
  logic [CMP_W-1:0] alu_a, alu_b;
  logic             alu_ge;

  ffha_store u_store (
    .clk (clk),
    .req (store_req),
    .rsp (store_rsp)
  );

  ffha_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .ge (alu_ge)
  );

  ffha_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_request_size   (in_request_size),
    .in_payload_offset (in_payload_offset),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_offset (out_result_offset),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .store_req         (store_req),
    .store_rsp         (store_rsp),
    .alu_a             (alu_a),
    .alu_b             (alu_b),
    .alu_ge            (alu_ge)
  );

endmodule

@@ verif/first_fit_heap_allocator_top_tb.sv @@
module first_fit_heap_allocator_top_tb;
  import ffha_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 100_000_000;
  localparam int PHASES = 4;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] offset;
  } heap_result_t;

  typedef struct {
    bit               is_cfg;
    logic [1:0]       action;
    logic [OFF_W-1:0] size_or_idx;
    logic [OFF_W-1:0] off_or_data;
    bit               typed;
    logic [1:0]       status;
    logic [OFF_W-1:0] offset;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [OFF_W-1:0] in_request_size = '0;
  logic [OFF_W-1:0] in_payload_offset = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [OFF_W-1:0] out_result_offset;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [PG_W-1:0] cfg_wdata = '0;

  first_fit_heap_allocator_top u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow heap
  int unsigned hp_size [GRANULES];
  bit          hp_free [GRANULES];
  int unsigned hp_prev [GRANULES];
  int unsigned hp_head, hp_tail, hp_pages;
  int unsigned cfg_init_pages = 16, cfg_page_limit = 64;

  heap_result_t pending_results[$];
  int unsigned  live_offsets[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;

  function automatic int unsigned blk_next(int unsigned i);
    return i + (HEADER_BYTES + hp_size[i]) / ALIGN_BYTES;
  endfunction

  function automatic int unsigned heap_extend(int unsigned want);
    int unsigned lim, avail, n, old_end, idx;
    bit empty;
    lim = (cfg_page_limit < ARENA_PAGES) ? cfg_page_limit : ARENA_PAGES;
    avail = (lim > hp_pages) ? lim - hp_pages : 0;
    n = (want < avail) ? want : avail;
    empty = (hp_pages == 0);
    old_end = hp_pages * PAGE_BYTES;
    if (n == 0) return 0;
    hp_pages += n;
    if (!empty && hp_free[hp_tail]) begin
      hp_size[hp_tail] += n * PAGE_BYTES;
    end else begin
      idx = old_end / ALIGN_BYTES;
      if (idx >= GRANULES) return n;
      hp_size[idx] = n * PAGE_BYTES - HEADER_BYTES;
      hp_free[idx] = 1'b1;
      hp_prev[idx] = empty ? 0 : hp_tail;
      if (empty) hp_head = idx;
      hp_tail = idx;
    end
    return n;
  endfunction

  function automatic heap_result_t heap_alloc(int unsigned req);
    int unsigned need, pages, i, s, nx;
    heap_result_t r;
    r = '{STAT_OK, '0};
    if (req == 0) begin r.status = STAT_REFUSED; return r; end
    if (req > ARENA_BYTES) begin r.status = STAT_NOMEM; return r; end
    need = (req + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
    pages = (need + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
    forever begin
      if (hp_pages > 0) begin
        i = hp_head;
        while (i < GRANULES) begin
          if (hp_free[i] && hp_size[i] >= need) begin
            if (hp_size[i] >= need + HEADER_BYTES + SPLIT_MIN) begin
              s = i + (HEADER_BYTES + need) / ALIGN_BYTES;
              if (i != hp_tail) begin
                nx = blk_next(i);
                if (nx < GRANULES) hp_prev[nx] = s;
              end else begin
                hp_tail = s;
              end
              hp_size[s] = hp_size[i] - need - HEADER_BYTES;
              hp_free[s] = 1'b1;
              hp_prev[s] = i;
              hp_size[i] = need;
            end
            hp_free[i] = 1'b0;
            r.offset = OFF_W'(i * ALIGN_BYTES + HEADER_BYTES);
            return r;
          end
          if (i == hp_tail) break;
          i = blk_next(i);
        end
      end
      if (heap_extend(pages) == 0) begin r.status = STAT_NOMEM; return r; end
    end
  endfunction

  function automatic heap_result_t heap_release(int unsigned off);
    int unsigned t, b, nx, nn, p;
    heap_result_t r;
    r = '{STAT_OK, '0};
    if (off == 0) begin r.status = STAT_REFUSED; return r; end
    if (hp_pages == 0 || off < HEADER_BYTES || (off - HEADER_BYTES) % ALIGN_BYTES != 0)
      return r;
    t = (off - HEADER_BYTES) / ALIGN_BYTES;
    b = hp_head;
    while (b < GRANULES && b != t) begin
      if (b == hp_tail || b > t) return r;
      b = blk_next(b);
    end
    if (b != t || b >= GRANULES || hp_free[b]) return r;
    hp_free[b] = 1'b1;
    // merge with the following block
    if (b != hp_tail) begin
      nx = blk_next(b);
      if (nx < GRANULES && hp_free[nx]) begin
        if (nx == hp_tail) hp_tail = b;
        else begin
          nn = blk_next(nx);
          if (nn < GRANULES) hp_prev[nn] = b;
        end
        hp_size[b] += HEADER_BYTES + hp_size[nx];
      end
    end
    // merge into the preceding block
    if (b != hp_head) begin
      p = hp_prev[b];
      if (p < GRANULES && hp_free[p]) begin
        if (b == hp_tail) hp_tail = p;
        else begin
          nx = blk_next(b);
          if (nx < GRANULES) hp_prev[nx] = p;
        end
        hp_size[p] += HEADER_BYTES + hp_size[b];
      end
    end
    return r;
  endfunction

  function automatic heap_result_t heap_predict(logic [1:0] act, int unsigned req,
                                                int unsigned off);
    heap_result_t r;
    r = '{STAT_REFUSED, '0};
    case (act)
      ACT_ALLOC: r = heap_alloc(req);
      ACT_FREE:  r = heap_release(off);
      ACT_INIT: begin
        hp_head = 0;
        hp_tail = 0;
        hp_pages = 0;
        r.status = (cfg_init_pages == 0 || heap_extend(cfg_init_pages) == 0) ?
                   STAT_INITF : STAT_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // check each result strobe against the oldest expectation
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_result_offset !== want.offset)
          report_mismatch("offset", out_result_offset, want.offset);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // present a request and hold it until accepted
  task automatic send_request(logic [1:0] act, logic [OFF_W-1:0] req, logic [OFF_W-1:0] off,
                              bit typed = 0, heap_result_t typed_res = '0);
    heap_result_t r;
    start <= 1'b1;
    in_action <= act;
    in_request_size <= req;
    in_payload_offset <= off;
    do @(posedge clk); while (busy);
    r = heap_predict(act, req, off);
    if (act == ACT_ALLOC && r.status == STAT_OK) live_offsets.push_back(r.offset);
    if (act == ACT_INIT) live_offsets.delete();
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [PG_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_INIT_PAGES) cfg_init_pages = data;
    else cfg_page_limit = data;
  endtask

  stim_row_t directed[] = '{
    '{0, ACT_ALLOC, 19'd16,     19'd0,      1, STAT_OK,      19'd32},
    '{0, ACT_ALLOC, 19'd0,      19'd0,      1, STAT_REFUSED, 19'd0},
    '{0, ACT_ALLOC, 19'd262145, 19'd0,      1, STAT_NOMEM,   19'd0},
    '{0, ACT_ALLOC, 19'h7FFFF,  19'h7FFFF,  1, STAT_NOMEM,   19'd0},
    '{0, ACT_FREE,  19'h7FFFF,  19'd0,      1, STAT_REFUSED, 19'd0},
    '{0, ACT_NONE,  19'h7FFFF,  19'h7FFFF,  1, STAT_REFUSED, 19'd0},
    '{0, ACT_FREE,  19'd0,      19'd32,     1, STAT_OK,      19'd0},
    '{0, ACT_INIT,  19'd0,      19'd0,      1, STAT_OK,      19'd0},
    '{0, ACT_ALLOC, 19'd1,      19'd0,      0, STAT_OK,      19'd0},
    '{0, ACT_ALLOC, 19'd100,    19'd0,      0, STAT_OK,      19'd0},
    '{0, ACT_ALLOC, 19'd4000,   19'd0,      0, STAT_OK,      19'd0},
    '{0, ACT_FREE,  19'd0,      19'd33,     1, STAT_OK,      19'd0},
    '{0, ACT_FREE,  19'd0,      19'd16,     1, STAT_OK,      19'd0},
    '{0, ACT_FREE,  19'd0,      19'h7FFFF,  0, STAT_OK,      19'd0},
    '{0, ACT_ALLOC, 19'd262144, 19'd0,      1, STAT_NOMEM,   19'd0},
    '{0, ACT_FREE,  19'd0,      19'd80,     0, STAT_OK,      19'd0},
    '{0, ACT_FREE,  19'd0,      19'd32,     0, STAT_OK,      19'd0},
    '{1, 2'd0,      CFG_INIT_PAGES, 19'd0,  0, STAT_OK,      19'd0},
    '{0, ACT_INIT,  19'd0,      19'd0,      1, STAT_INITF,   19'd0},
    '{0, ACT_ALLOC, 19'd64,     19'd0,      0, STAT_OK,      19'd0},
    '{1, 2'd0,      CFG_PAGE_LIMIT, 19'd0,  0, STAT_OK,      19'd0},
    '{0, ACT_INIT,  19'd0,      19'd0,      1, STAT_INITF,   19'd0},
    '{0, ACT_ALLOC, 19'd16,     19'd0,      1, STAT_NOMEM,   19'd0},
    '{1, 2'd0,      CFG_INIT_PAGES, 19'd64, 0, STAT_OK,      19'd0},
    '{1, 2'd0,      CFG_PAGE_LIMIT, 19'd127, 0, STAT_OK,     19'd0},
    '{0, ACT_INIT,  19'd0,      19'd0,      1, STAT_OK,      19'd0},
    '{0, ACT_ALLOC, 19'd258000, 19'd0,      0, STAT_OK,      19'd0}
  };

  int idle_pct[PHASES] = '{0, 78, 0, 18};

  initial begin
    int unsigned pick, req, off, k;
    logic [1:0] act;
    hp_head = 0;
    hp_tail = 0;
    hp_pages = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed[r]) begin
      if (directed[r].is_cfg)
        write_reg(directed[r].size_or_idx[1:0], directed[r].off_or_data[PG_W-1:0]);
      else
        send_request(directed[r].action, directed[r].size_or_idx, directed[r].off_or_data,
                     directed[r].typed, '{directed[r].status, directed[r].offset});
    end

    // random phases, each under a fresh setting of the registers
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin write_reg(CFG_INIT_PAGES, 7'd1);   write_reg(CFG_PAGE_LIMIT, 7'd64); end
        1: begin write_reg(CFG_INIT_PAGES, 7'd127); write_reg(CFG_PAGE_LIMIT, 7'd8); end
        2: begin write_reg(CFG_INIT_PAGES, 7'd64);  write_reg(CFG_PAGE_LIMIT, 7'd127); end
        default: begin
          write_reg(CFG_INIT_PAGES, PG_W'($urandom_range(1, 64)));
          write_reg(CFG_PAGE_LIMIT, PG_W'($urandom_range(1, 64)));
        end
      endcase
      send_request(ACT_INIT, '0, '0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender gap, idle cycle by cycle at the phase's rate
        while ($urandom_range(99) < idle_pct[ph]) begin
          start <= 1'b0;
          @(posedge clk);
        end
        pick = $urandom_range(99);
        req = $urandom_range(1, 512);
        off = 0;
        act = ACT_ALLOC;
        if (pick < 50) begin
          k = $urandom_range(99);
          if (k < 10) req = $urandom_range(513, 9000);
          else if (k < 12) req = $urandom_range(0, 19'h7FFFF);
          else if (k < 13) req = 0;
        end else if (pick < 88) begin
          act = ACT_FREE;
          if (live_offsets.size() != 0 && $urandom_range(9) != 0) begin
            k = $urandom_range(live_offsets.size() - 1);
            off = live_offsets[k];
            live_offsets.delete(k);
          end else begin
            off = $urandom_range(0, 19'h7FFFF);
          end
          req = $urandom_range(0, 19'h7FFFF);
        end else if (pick < 92) begin
          act = ACT_INIT;
        end else if (pick < 95) begin
          act = ACT_NONE;
          req = $urandom_range(0, 19'h7FFFF);
          off = $urandom_range(0, 19'h7FFFF);
        end
        send_request(act, OFF_W'(req), OFF_W'(off));
      end
    end

    drain();
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
design/ffha_pkg.sv
design/ffha_store.sv
design/ffha_alu.sv
design/ffha_seq.sv
design/first_fit_heap_allocator_top.sv
verif/first_fit_heap_allocator_top_tb.sv
